/* rtl/assert_macros.svh */
// Concurrent assertion helpers; bodies vanish in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

/* rtl/cpc_pkg.sv */
package cpc_pkg;

  localparam int QW = 24;
  localparam logic [16:0] K_RESET = 17'd65536;
  localparam logic [16:0] K_MAX = 17'h1FFFF;
  localparam logic [23:0] EC_MAX = 24'hFFFFFF;

  localparam logic CFG_K_LOW = 1'b0;
  localparam logic CFG_K_HIGH = 1'b1;

  typedef enum logic [1:0] {OP_MEASURE, OP_ENTER, OP_CAL, OP_EXIT} op_t;

  typedef enum logic [2:0] {
    MSG_NEED_CAL, MSG_INSERT, MSG_LOW_BUF, MSG_HIGH_BUF, MSG_ERROR, MSG_SUCCESS
  } msg_t;

  typedef enum logic [1:0] {BUF_NONE, BUF_LOW, BUF_HIGH} buf_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_PROD, ST_RANGE, ST_PROD2, ST_PREP, ST_DIV,
    ST_DIV_WAIT, ST_APPLY
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] voltage_dmv;
    logic [8:0]  temperature_dc;
  } in_t;

  typedef struct packed {
    logic [23:0] ec_value;
    logic        ec_saturated;
    logic        high_range_active;
    logic [2:0]  message_code;
    logic [1:0]  cal_step;
    logic        probe_calibrated;
    logic        save_low;
    logic        save_high;
    logic [16:0] saved_k;
  } out_t;

  typedef struct packed {
    logic capture;
    logic prod;
    logic range;
    logic prep;
    logic div_start;
    logic apply;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic in_cal;
    logic do_div;
    logic div_done;
    logic out_free;
  } status_t;

  // raw conductivity is dmv / 1640 mS/cm
  function automatic buf_t buffer_of(input logic [15:0] dmv);
    buf_t b;
    b = BUF_NONE;
    if (dmv > 16'd1476 && dmv < 16'd3280) b = BUF_LOW;
    else if (dmv > 16'd14760 && dmv < 16'd27552) b = BUF_HIGH;
    return b;
  endfunction

endpackage

/* rtl/cpc_divider.sv */
module cpc_divider #(
  parameter int DIV_W = 63
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIV_W-1:0]      dividend,
  input  logic [DIV_W-1:0]      divisor,
  output logic                  done,
  output logic                  ovf,
  output logic [cpc_pkg::QW-1:0] quotient
);
  import cpc_pkg::*;

  localparam int CW = $clog2(QW);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsh;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             ge;

  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsh <= divisor << (QW - 1);
      ovf <= dividend >= (divisor << QW);
      cnt <= CW'(QW - 1);
    end else if (busy) begin
      // restoring step: one quotient bit per cycle, MSB first
      if (ge) rem <= rem - dsh;
      quotient <= {quotient[QW-2:0], ge};
      dsh <= dsh >> 1;
      cnt <= cnt - 1'b1;
    end
  end

endmodule

/* rtl/cpc_ctrl.sv */
module cpc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  cpc_pkg::status_t status,
  output cpc_pkg::cmd_t    cmd,
  output cpc_pkg::state_t  state
);
  import cpc_pkg::*;

  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        if (status.op == OP_MEASURE) state_next = ST_PROD;
        else if (status.op == OP_CAL && status.in_cal) state_next = ST_PROD;
        else state_next = ST_APPLY;
      end
      ST_PROD:     state_next = (status.op == OP_MEASURE) ? ST_RANGE : ST_PREP;
      ST_RANGE:    state_next = ST_PROD2;
      ST_PROD2:    state_next = ST_PREP;
      ST_PREP:     state_next = status.do_div ? ST_DIV : ST_APPLY;
      ST_DIV:      state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (status.div_done) state_next = ST_APPLY;
      ST_APPLY:    if (status.out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.capture = in_valid;
      end
      ST_PROD, ST_PROD2: cmd.prod = 1'b1;
      ST_RANGE:          cmd.range = 1'b1;
      ST_PREP:           cmd.prep = 1'b1;
      ST_DIV:            cmd.div_start = 1'b1;
      ST_APPLY:          cmd.apply = status.out_free;
      default:           cmd = '0;
    endcase
  end

endmodule

/* rtl/cpc_datapath.sv */
module cpc_datapath #(
  parameter int K_FRAC_BITS = 16,
  parameter int DIV_W = 63
) (
  input  logic             clk,
  input  logic             rst,
  input  cpc_pkg::cmd_t    cmd,
  output cpc_pkg::status_t status,
  input  cpc_pkg::in_t     in_data,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [16:0]      cfg_data,
  output logic             out_valid,
  input  logic             out_stall,
  output cpc_pkg::out_t    out_data
);
  import cpc_pkg::*;

  localparam logic [39:0] RANGE_UP = 40'(8200) << K_FRAC_BITS;
  localparam logic [39:0] RANGE_DN = 40'(3280) << K_FRAC_BITS;

  op_t         op;
  logic [15:0] dmv;
  logic [14:0] factor;
  logic [32:0] prod;
  logic [20:0] fac41;
  logic [34:0] cal_num;
  logic [34:0] cal_den;
  logic [DIV_W-1:0] dividend;
  logic [DIV_W-1:0] divisor;
  buf_t        buf_sel;
  logic        accept;

  logic        use_high;
  logic [16:0] k_low;
  logic [16:0] k_high;
  logic        in_cal;
  logic        cal_fin;
  logic        calib;
  logic [1:0]  step;
  logic [2:0]  msg;

  logic        use_high_next;
  logic [16:0] k_low_next;
  logic [16:0] k_high_next;
  logic        in_cal_next;
  logic        cal_fin_next;
  logic        calib_next;
  logic [1:0]  step_next;
  logic [2:0]  msg_next;
  out_t        res;

  buf_t        buf_now;
  logic [16:0] kcur;
  logic [19:0] b41;
  logic [36:0] num2;
  logic [36:0] den3;
  logic        acc_c;
  logic        div_done;
  logic        div_ovf;
  logic [QW-1:0] quot;
  logic [16:0] k_cal;

  assign buf_now = buffer_of(dmv);
  assign kcur = use_high ? k_high : k_low;
  assign b41 = (buf_now == BUF_HIGH) ? 20'd528080 : 20'd57933;
  assign num2 = {1'b0, cal_num, 1'b0};
  assign den3 = {2'b0, cal_den} + {1'b0, cal_den, 1'b0};
  assign acc_c = (num2 > 37'(cal_den)) && (num2 < den3);
  assign k_cal = (quot > QW'(K_MAX)) ? K_MAX : quot[16:0];

  cpc_divider #(.DIV_W(DIV_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .ovf      (div_ovf),
    .quotient (quot)
  );

  assign status.op = op;
  assign status.in_cal = in_cal;
  assign status.do_div = (op == OP_MEASURE) || (buf_now != BUF_NONE && acc_c);
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= op_t'(in_data.op);
      dmv <= in_data.voltage_dmv;
      factor <= 15'(17'd10750 + 17'd37 * 17'(in_data.temperature_dc));
    end
    if (cmd.prod) begin
      prod <= 33'(dmv) * 33'(kcur);
      fac41 <= 21'(factor) * 21'd41;
      cal_num <= 35'(b41) * 35'(factor);
      cal_den <= 35'(dmv) * 35'd500000;
    end
    if (cmd.prep) begin
      buf_sel <= buf_now;
      accept <= acc_c;
      // round to nearest: (2n + d) / 2d
      if (op == OP_MEASURE) begin
        dividend <= ((DIV_W'(prod) * DIV_W'(500)) << 17)
                    + (DIV_W'(fac41) << K_FRAC_BITS);
        divisor <= DIV_W'({fac41, 1'b0}) << K_FRAC_BITS;
      end else begin
        dividend <= (DIV_W'(cal_num) << (K_FRAC_BITS + 1)) + DIV_W'(cal_den);
        divisor <= DIV_W'({cal_den, 1'b0});
      end
    end
    if (cmd.apply) out_data <= res;
  end

  always_comb begin
    use_high_next = use_high;
    k_low_next = k_low;
    k_high_next = k_high;
    in_cal_next = in_cal;
    cal_fin_next = cal_fin;
    calib_next = calib;
    step_next = step;
    msg_next = msg;
    res = '0;
    unique case (op)
      OP_MEASURE: begin
        res.ec_value = div_ovf ? EC_MAX : quot;
        res.ec_saturated = div_ovf;
      end
      OP_ENTER: begin
        in_cal_next = 1'b1;
        cal_fin_next = 1'b0;
        msg_next = MSG_INSERT;
        step_next = 2'd1;
      end
      OP_CAL: begin
        if (in_cal) begin
          if (buf_sel == BUF_NONE) begin
            cal_fin_next = 1'b0;
            msg_next = MSG_ERROR;
          end else if (accept) begin
            if (buf_sel == BUF_LOW) k_low_next = k_cal;
            else k_high_next = k_cal;
            cal_fin_next = 1'b1;
            calib_next = 1'b1;
            msg_next = MSG_SUCCESS;
            step_next = 2'd2;
          end else begin
            cal_fin_next = 1'b0;
            calib_next = 1'b0;
            msg_next = MSG_ERROR;
            step_next = 2'd0;
          end
        end
      end
      OP_EXIT: begin
        if (in_cal) begin
          if (cal_fin) begin
            if (buf_now == BUF_LOW) begin
              res.save_low = 1'b1;
              res.saved_k = k_low;
            end else if (buf_now == BUF_HIGH) begin
              res.save_high = 1'b1;
              res.saved_k = k_high;
            end
          end
          cal_fin_next = 1'b0;
          in_cal_next = 1'b0;
        end
      end
      default: res = '0;
    endcase
    res.high_range_active = use_high_next;
    res.message_code = msg_next;
    res.cal_step = step_next;
    res.probe_calibrated = calib_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_high <= 1'b0;
      k_low <= K_RESET;
      k_high <= K_RESET;
      in_cal <= 1'b0;
      cal_fin <= 1'b0;
      calib <= 1'b0;
      step <= 2'd0;
      msg <= MSG_NEED_CAL;
    end else begin
      // hysteresis on the product with the constant in use: up above 2.5, down below 2.0
      if (cmd.range) begin
        if ({7'b0, prod} << 1 > RANGE_UP) use_high <= 1'b1;
        else if (40'(prod) < RANGE_DN) use_high <= 1'b0;
      end
      if (cmd.apply) begin
        use_high <= use_high_next;
        k_low <= k_low_next;
        k_high <= k_high_next;
        in_cal <= in_cal_next;
        cal_fin <= cal_fin_next;
        calib <= calib_next;
        step <= step_next;
        msg <= msg_next;
      end
      if (cfg_write) begin
        if (cfg_index == CFG_K_LOW) k_low <= cfg_data;
        else k_high <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.apply) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

endmodule

/* rtl/conductivity_probe_converter_core.sv */
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | cpc_pkg::in_t (op, voltage, temperature)
// out     | output    | out_valid / out_stall| cpc_pkg::out_t
// cfg     | input     | cfg_valid / cfg_ready| cfg_index (0 k_low, 1 k_high), cfg_data
// Measure runs decode, product, range update, second product, division prep, divider
// start and a wait on the 24 quotient bits and done; apply registers the beat. Calibrate
// with an accepted K skips range update and second product, else also the divider;
// enter, exit and calibrate outside calibration go from decode to apply. in_stall is
// high from accept until the result is registered; a stalled result holds the apply
// cycle. Synchronous reset clears control state and loads both cell constants with 1.0.
module conductivity_probe_converter_core #(
  parameter int K_FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  cpc_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output cpc_pkg::out_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [16:0]    cfg_data
);
  import cpc_pkg::*;

`include "assert_macros.svh"

  localparam int DIV_W = (K_FRAC_BITS + 47 > 60) ? K_FRAC_BITS + 47 : 60;

  cmd_t    cmd;
  status_t status;
  state_t  state;

  assign cfg_ready = 1'b1;

  cpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  cpc_datapath #(.K_FRAC_BITS(K_FRAC_BITS), .DIV_W(DIV_W)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `ASSERT_NEXT(a_accept_blocks, clk, rst, in_valid && !in_stall, in_stall)
  `ASSERT_NEXT(a_div_restart, clk, rst, cmd.div_start, !status.div_done)
  `ASSERT_NEXT(a_apply_shows, clk, rst, cmd.apply, out_valid)
  `ASSERT_SAME(a_wait_busy, clk, rst, state == ST_DIV_WAIT, in_stall && !cmd.apply)

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import cpc_pkg::*;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  in_t           in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  out_t          out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic          cfg_index = CFG_K_LOW;
  logic [16:0]   cfg_data = '0;

  conductivity_probe_converter_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // probe model state
  logic        pm_high;
  logic [16:0] pm_k_low, pm_k_high;
  logic        pm_in_cal, pm_cal_done, pm_calibrated;
  logic [1:0]  pm_step;
  logic [2:0]  pm_msg;

  out_t   expected_q[$];
  int     mismatches = 0;
  int     result_count = 0;
  int     sent_count = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;

  function automatic buf_t buffer_class(input logic [15:0] dmv);
    if (dmv > 16'd1476 && dmv < 16'd3280) return BUF_LOW;
    if (dmv > 16'd14760 && dmv < 16'd27552) return BUF_HIGH;
    return BUF_NONE;
  endfunction

  function automatic out_t convert_probe(input in_t it);
    out_t r;
    logic [63:0] kcur, prod, num, den, ec, factor, bval, k;
    buf_t b;
    r = '0;
    factor = 64'd10750 + 64'd37 * it.temperature_dc;
    case (op_t'(it.op))
      OP_MEASURE: begin
        kcur = pm_high ? pm_k_high : pm_k_low;
        prod = it.voltage_dmv * kcur;
        if (prod * 2 > 64'd8200 * 65536) pm_high = 1'b1;
        else if (prod < 64'd3280 * 65536) pm_high = 1'b0;
        kcur = pm_high ? pm_k_high : pm_k_low;
        num = it.voltage_dmv * kcur * 500 * 65536;
        den = 64'd41 * 65536 * factor;
        ec = (num + den / 2) / den;
        if (ec > 64'hFFFFFF) begin
          ec = 64'hFFFFFF;
          r.ec_saturated = 1'b1;
        end
        r.ec_value = ec[23:0];
      end
      OP_ENTER: begin
        pm_in_cal = 1'b1;
        pm_cal_done = 1'b0;
        pm_msg = MSG_INSERT;
        pm_step = 2'd1;
      end
      OP_CAL: if (pm_in_cal) begin
        b = buffer_class(it.voltage_dmv);
        if (b == BUF_NONE) begin
          pm_cal_done = 1'b0;
          pm_msg = MSG_ERROR;
        end else begin
          bval = (b == BUF_LOW) ? 64'd1413 : 64'd12880;
          num = 64'd41 * bval * factor;
          den = 64'd500000 * it.voltage_dmv;
          if (num * 2 > den && num * 2 < den * 3) begin
            k = (num * 65536 + den / 2) / den;
            if (k > 64'h1FFFF) k = 64'h1FFFF;
            if (b == BUF_LOW) pm_k_low = k[16:0];
            else pm_k_high = k[16:0];
            pm_cal_done = 1'b1;
            pm_calibrated = 1'b1;
            pm_msg = MSG_SUCCESS;
            pm_step = 2'd2;
          end else begin
            pm_cal_done = 1'b0;
            pm_calibrated = 1'b0;
            pm_msg = MSG_ERROR;
            pm_step = 2'd0;
          end
        end
      end
      default: if (pm_in_cal) begin
        if (pm_cal_done) begin
          b = buffer_class(it.voltage_dmv);
          if (b == BUF_LOW) begin
            r.save_low = 1'b1;
            r.saved_k = pm_k_low;
          end else if (b == BUF_HIGH) begin
            r.save_high = 1'b1;
            r.saved_k = pm_k_high;
          end
        end
        pm_cal_done = 1'b0;
        pm_in_cal = 1'b0;
      end
    endcase
    r.high_range_active = pm_high;
    r.message_code = pm_msg;
    r.cal_step = pm_step;
    r.probe_calibrated = pm_calibrated;
    return r;
  endfunction

  task automatic send_item(input op_t op, input logic [15:0] dmv, input logic [8:0] tdc);
    in_t it;
    it.op = op;
    it.voltage_dmv = dmv;
    it.temperature_dc = tdc;
    @(negedge clk);
    // drop valid while the sender idles
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(convert_probe(it));
    sent_count++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_k(input logic idx, input logic [16:0] val);
    drain();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_K_LOW) pm_k_low = val;
    else pm_k_high = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver stall and result checking
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    out_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      result_count++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_data.ec_value !== exp_r.ec_value ||
            out_data.ec_saturated !== exp_r.ec_saturated ||
            out_data.high_range_active !== exp_r.high_range_active ||
            out_data.message_code !== exp_r.message_code ||
            out_data.cal_step !== exp_r.cal_step ||
            out_data.probe_calibrated !== exp_r.probe_calibrated ||
            out_data.save_low !== exp_r.save_low ||
            out_data.save_high !== exp_r.save_high ||
            out_data.saved_k !== exp_r.saved_k) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: expected %h actual %h",
                     result_count, exp_r, out_data);
        end
      end
    end
  end

  function automatic logic [15:0] rand_dmv;
    case ($urandom_range(5))
      0: return 16'($urandom_range(1477, 3279));
      1: return 16'($urandom_range(14761, 27551));
      2: return 16'($urandom_range(3000, 5000));
      3: return 16'($urandom_range(50000));
      4: return 16'($urandom_range(65535));
      default: return 16'($urandom_range(1470, 1480));
    endcase
  endfunction

  function automatic logic [8:0] rand_tdc;
    return ($urandom_range(9) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(500));
  endfunction

  task automatic test_directed;
    send_item(OP_MEASURE, 16'd0, 9'd0);
    send_item(OP_MEASURE, 16'd65535, 9'd511);
    send_item(OP_MEASURE, 16'd65535, 9'd0);
    send_item(OP_MEASURE, 16'd3000, 9'd250);
    send_item(OP_CAL, 16'd2300, 9'd250);
    send_item(OP_EXIT, 16'd2300, 9'd250);
    send_item(OP_ENTER, 16'd0, 9'd0);
    send_item(OP_CAL, 16'd100, 9'd250);
    send_item(OP_CAL, 16'd1477, 9'd0);
    send_item(OP_CAL, 16'd2317, 9'd250);
    send_item(OP_EXIT, 16'd2317, 9'd250);
    send_item(OP_ENTER, 16'd0, 9'd0);
    send_item(OP_CAL, 16'd21123, 9'd250);
    send_item(OP_EXIT, 16'd5000, 9'd250);
    send_item(OP_ENTER, 16'd0, 9'd0);
    send_item(OP_CAL, 16'd27551, 9'd500);
    send_item(OP_EXIT, 16'd21000, 9'd250);
    send_item(OP_MEASURE, 16'd8200, 9'd250);
    send_item(OP_MEASURE, 16'd3279, 9'd250);
    send_item(OP_MEASURE, 16'd3280, 9'd250);
  endtask

  task automatic test_random(input int n);
    op_t op;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1, 2: op = OP_MEASURE;
        3: op = OP_ENTER;
        4, 5, 6: op = OP_CAL;
        7, 8: op = OP_EXIT;
        default: op = op_t'($urandom_range(3));
      endcase
      send_item(op, rand_dmv(), rand_tdc());
    end
  endtask

  task automatic test_config_extremes;
    write_k(CFG_K_LOW, 17'd0);
    write_k(CFG_K_HIGH, 17'h1FFFF);
    test_random(60);
    write_k(CFG_K_LOW, 17'h1FFFF);
    write_k(CFG_K_HIGH, 17'd0);
    test_random(60);
    write_k(CFG_K_LOW, 17'($urandom_range(40000, 90000)));
    write_k(CFG_K_HIGH, 17'($urandom_range(40000, 90000)));
  endtask

  initial begin
    pm_high = 1'b0;
    pm_k_low = K_RESET;
    pm_k_high = K_RESET;
    pm_in_cal = 1'b0;
    pm_cal_done = 1'b0;
    pm_calibrated = 1'b0;
    pm_step = 2'd0;
    pm_msg = MSG_NEED_CAL;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_extremes();
    test_random(400);
    send_idle_pct = 84;
    test_random(350);
    send_idle_pct = 0;
    recv_stall_pct = 84;
    test_random(350);
    send_idle_pct = 33;
    recv_stall_pct = 33;
    test_random(350);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(60);
    drain();
    $display("Covered %0d beats over all ops, range switching, calibration and cell constant writes",
             sent_count);
    $display("with sender gaps and receiver stalls; %0d results checked", result_count);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS conductivity_probe_converter_core");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, expected_q.size());
      $display("FAIL conductivity_probe_converter_core");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("FAIL conductivity_probe_converter_core");
    $finish;
  end

endmodule
